// ----- rtl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the i2c master bit sequencer modules.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // command codes carried by req_type, code 7 means nothing
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_SACK  = 3'd5,
    CMD_RACK  = 3'd6
  } cmd_t;

  localparam int StepW = 5;

  // sequence lengths in pin steps
  localparam logic [StepW-1:0] LenStart = 5'd4;
  localparam logic [StepW-1:0] LenStop  = 5'd3;
  localparam logic [StepW-1:0] LenWrite = 5'd24;
  localparam logic [StepW-1:0] LenRead  = 5'd17;
  localparam logic [StepW-1:0] LenAck   = 5'd3;

  // msb of the transmit shifter
  localparam logic [7:0] MsbMask = 8'h80;

  // sequencer state
  typedef struct packed {
    cmd_t             cmd;
    logic [StepW-1:0] step;
    logic [1:0]       phase;     // write bit phase, step modulo three
    logic [7:0]       tx_shift;
    logic [7:0]       rx_shift;
    logic             scl;
    logic             sda;
    logic             ack_reg;
    logic             ack_out;
  } seq_state_t;

  localparam seq_state_t SeqReset = '{
    cmd:      CMD_NONE,
    step:     '0,
    phase:    2'd0,
    tx_shift: 8'h00,
    rx_shift: 8'h00,
    scl:      1'b1,
    sda:      1'b1,
    ack_reg:  1'b1,
    ack_out:  1'b0
  };

  // result word of one tick
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       cmd_done;
    logic       busy_res;
    logic       rejected;
  } seq_result_t;

  function automatic logic [StepW-1:0] seq_len(cmd_t cmd);
    logic [StepW-1:0] len;
    case (cmd)
      CMD_START: len = LenStart;
      CMD_STOP:  len = LenStop;
      CMD_WRITE: len = LenWrite;
      CMD_READ:  len = LenRead;
      CMD_SACK:  len = LenAck;
      CMD_RACK:  len = LenAck;
      default:   len = '0;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/i2cm_step.sv -----
// ----------------------------------------------------------------------------
// i2cm_step
// One tick of the sequencer: command intake and one pin step of the active
// command, giving the next state and the result word.
// ----------------------------------------------------------------------------
module i2cm_step (
  input  i2cm_pkg::seq_state_t  cur,
  input  logic [2:0]            req_type,
  input  logic [7:0]            tx_byte,
  input  logic                  ack_bit,
  input  logic                  sda_in,
  output i2cm_pkg::seq_state_t  nxt,
  output i2cm_pkg::seq_result_t res
);

  i2cm_pkg::seq_state_t   s;
  logic                   req_ok;
  logic                   rej;
  logic                   done;
  logic [i2cm_pkg::StepW-1:0] step_inc;

  always_comb begin
    s        = cur;
    rej      = 1'b0;
    done     = 1'b0;
    req_ok   = req_type inside {[i2cm_pkg::CMD_START : i2cm_pkg::CMD_RACK]};
    step_inc = '0;

    // command intake, only when idle
    if (req_ok) begin
      if (s.cmd == i2cm_pkg::CMD_NONE) begin
        s.cmd   = i2cm_pkg::cmd_t'(req_type);
        s.step  = '0;
        s.phase = 2'd0;
        if (s.cmd == i2cm_pkg::CMD_WRITE) s.tx_shift = tx_byte;
        if (s.cmd == i2cm_pkg::CMD_READ) s.rx_shift = 8'h00;
        if (s.cmd == i2cm_pkg::CMD_SACK) s.ack_out = ack_bit;
      end else begin
        rej = 1'b1;
      end
    end

    // one pin step of the active command
    case (s.cmd)
      i2cm_pkg::CMD_START: begin
        case (s.step)
          5'd0:    s.sda = 1'b1;
          5'd1:    s.scl = 1'b1;
          5'd2:    s.sda = 1'b0;
          default: s.scl = 1'b0;
        endcase
      end
      i2cm_pkg::CMD_STOP: begin
        case (s.step)
          5'd0:    s.sda = 1'b0;
          5'd1:    s.scl = 1'b1;
          default: s.sda = 1'b1;
        endcase
      end
      i2cm_pkg::CMD_WRITE: begin
        case (s.phase)
          2'd0:    s.sda = |(s.tx_shift & i2cm_pkg::MsbMask);
          2'd1:    s.scl = 1'b1;
          default: begin
            s.scl      = 1'b0;
            s.tx_shift = {s.tx_shift[6:0], 1'b0};
          end
        endcase
      end
      i2cm_pkg::CMD_READ: begin
        if (s.step == '0) begin
          s.sda = 1'b1;
        end else if (s.step[0]) begin
          s.scl      = 1'b1;
          s.rx_shift = {s.rx_shift[6:0], sda_in};
        end else begin
          s.scl = 1'b0;
        end
      end
      i2cm_pkg::CMD_SACK: begin
        case (s.step)
          5'd0:    s.sda = s.ack_out;
          5'd1:    s.scl = 1'b1;
          default: s.scl = 1'b0;
        endcase
      end
      i2cm_pkg::CMD_RACK: begin
        case (s.step)
          5'd0:    s.sda = 1'b1;
          5'd1: begin
            s.scl     = 1'b1;
            s.ack_reg = sda_in;
          end
          default: s.scl = 1'b0;
        endcase
      end
      default: ;
    endcase

    // step count and end of sequence
    if (s.cmd != i2cm_pkg::CMD_NONE) begin
      step_inc = s.step + 5'd1;
      s.step   = step_inc;
      s.phase  = (s.phase == 2'd2) ? 2'd0 : s.phase + 2'd1;
      if (step_inc == i2cm_pkg::seq_len(s.cmd)) begin
        done    = 1'b1;
        s.cmd   = i2cm_pkg::CMD_NONE;
        s.step  = '0;
        s.phase = 2'd0;
      end
    end

    nxt          = s;
    res.scl_out  = s.scl;
    res.sda_out  = s.sda;
    res.rx_byte  = s.rx_shift;
    res.ack_seen = s.ack_reg;
    res.cmd_done = done;
    res.busy_res = (s.cmd != i2cm_pkg::CMD_NONE);
    res.rejected = rej;
  end

endmodule

// ----- rtl/i2c_master_bit_sequencer.sv -----
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Byte level i2c master that drives SCL and SDA one pin step per input word.
// ----------------------------------------------------------------------------
// Each accepted input word is one bus tick from an external prescaler. An
// idle sequencer takes a command (start 4 ticks, stop 3, write byte 24, read
// byte 17, send or receive ack 3) and performs its first pin step in the same
// tick; a command given while busy is dropped and flagged by rejected. Every
// input word yields exactly one result word in the next cycle, and a new word
// is taken every cycle: the tick logic sits between the state register and a
// single result register, which keeps accepting as long as its word is taken
// or absent. sda_out is open drain: 1 releases the line.
module i2c_master_bit_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] req_type,
  input  logic [7:0] tx_byte,
  input  logic       ack_bit,
  input  logic       sda_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       scl_out,
  output logic       sda_out,
  output logic [7:0] rx_byte,
  output logic       ack_seen,
  output logic       cmd_done,
  output logic       busy_res,
  output logic       rejected
);

  i2cm_pkg::seq_state_t  st;
  i2cm_pkg::seq_state_t  st_next;
  i2cm_pkg::seq_result_t res;
  i2cm_pkg::seq_result_t res_next;
  logic                  accept;

  // result register is free when empty or being taken
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // tick logic
  i2cm_step u_step (
    .cur      (st),
    .req_type (req_type),
    .tx_byte  (tx_byte),
    .ack_bit  (ack_bit),
    .sda_in   (sda_in),
    .nxt      (st_next),
    .res      (res_next)
  );

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= i2cm_pkg::SeqReset;
      out_valid <= 1'b0;
    end else begin
      if (accept) st <= st_next;
      if (in_ready) out_valid <= in_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) res <= res_next;
  end

  assign scl_out  = res.scl_out;
  assign sda_out  = res.sda_out;
  assign rx_byte  = res.rx_byte;
  assign ack_seen = res.ack_seen;
  assign cmd_done = res.cmd_done;
  assign busy_res = res.busy_res;
  assign rejected = res.rejected;

  // idle sequencer holds a cleared step count
  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    (st.cmd == i2cm_pkg::CMD_NONE) |-> (st.step == '0 && st.phase == 2'd0))
    else $error("idle sequencer with nonzero step count");

  // step count stays below the longest sequence
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    st.step < i2cm_pkg::LenWrite)
    else $error("step count out of range");

  // a finished command never reports busy
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cmd_done) |-> !busy_res)
    else $error("command done while still busy");

  // a valid request to a busy sequencer is rejected
  a_reject: assert property (@(posedge clk) disable iff (rst)
    (accept && st.cmd != i2cm_pkg::CMD_NONE &&
     req_type >= i2cm_pkg::CMD_START && req_type <= i2cm_pkg::CMD_RACK)
    |=> (out_valid && rejected))
    else $error("request while busy not rejected");

endmodule
